### rtl/core/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants of the size literal parser: error codes,
// unit codes and the transaction that travels from the front to the back.
// ----------------------------------------------------------------------------
package slp_pkg;

    // Status / error codes, sticky until the end of a literal
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_INVAL = 2'd1;
    localparam logic [1:0] ERR_OFLOW = 2'd2;

    // Unit codes
    localparam logic [2:0] UNIT_NONE = 3'd0;
    localparam logic [2:0] UNIT_B    = 3'd1;
    localparam logic [2:0] UNIT_K    = 3'd2;
    localparam logic [2:0] UNIT_M    = 3'd3;
    localparam logic [2:0] UNIT_G    = 3'd4;
    localparam logic [2:0] UNIT_T    = 3'd5;

    // Number of x1000 / x1024 scale steps for the largest unit (t)
    localparam int SCALE_STEPS = 4;

    // Largest value that survives one decimal scale step
    localparam logic [63:0] DEC_STEP_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;

    // Token handed from the parser front to the arithmetic back
    typedef struct packed {
        logic        last;      // literal ends with this token
        logic        commit;    // add value times unit to the total
        logic        binary;    // powers of two unit
        logic [2:0]  unit;      // unit of the committed term
        logic [1:0]  err;       // error found by the front, after the commit
        logic [63:0] value;     // number of the committed term
    } token_t;

endpackage

### rtl/core/slp_if.sv
// ----------------------------------------------------------------------------
// slp_if
// Valid/ready channels of the size literal parser: one for literal bytes,
// one for parse results.
// ----------------------------------------------------------------------------
interface slp_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface slp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] total_bytes;

    modport source (output valid, output status, output total_bytes, input ready);
    modport sink   (input valid, input status, input total_bytes, output ready);
endinterface

### rtl/core/slp_front.sv
// ----------------------------------------------------------------------------
// slp_front
// Character parser: folds case, tracks the phase of the current term,
// accumulates the decimal number and emits commit/error/end tokens.
// ----------------------------------------------------------------------------
module slp_front
(
    input  logic              clk,
    input  logic              rst_n,
    slp_item_if.sink          items,
    input  logic              tok_space,
    output logic              tok_valid,
    output slp_pkg::token_t   tok
);
    import slp_pkg::*;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_SEP    = 3'd2;
    localparam logic [2:0] PH_BYTES  = 3'd3;
    localparam logic [2:0] PH_PREFIX = 3'd4;
    localparam logic [2:0] PH_IB     = 3'd5;
    localparam logic [2:0] PH_AFTER  = 3'd6;

    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_K     = 8'h6B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_Y     = 8'h79;

    function automatic logic [2:0] unit_of(input logic [7:0] c);
        logic [2:0] u;
        begin
            u = UNIT_NONE;
            if (c == CH_B) u = UNIT_B;
            if (c == CH_K) u = UNIT_K;
            if (c == CH_M) u = UNIT_M;
            if (c == CH_G) u = UNIT_G;
            if (c == CH_T) u = UNIT_T;
            return u;
        end
    endfunction

    function automatic logic [7:0] tail_char(input logic [1:0] pos);
        logic [7:0] ch;
        begin
            unique case (pos)
                2'd0:    ch = CH_Y;
                2'd1:    ch = CH_T;
                2'd2:    ch = CH_E;
                default: ch = CH_S;
            endcase
            return ch;
        end
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [63:0] term_reg, term_next;
    logic [2:0]  unit_reg, unit_next;
    logic [1:0]  pos_reg, pos_next;
    logic        halt_reg, halt_next;

    logic [7:0]  c;
    logic        is_digit, is_sep, do_after, accept;
    logic [3:0]  dval;
    logic [67:0] mul10;
    logic        digit_ovf;
    logic [2:0]  new_unit;
    token_t      t;

    assign accept      = items.valid && items.ready;
    assign items.ready = tok_space;

    always_comb
    begin
        c = (items.char_in >= CH_UP_A && items.char_in <= CH_UP_Z)
            ? items.char_in + CASE_OFS : items.char_in;
        is_digit  = (c >= CH_0) && (c <= CH_9);
        is_sep    = (c == CH_SPACE) || (c == CH_COMMA);
        dval      = c[3:0];
        mul10     = ({4'b0, term_reg} << 3) + ({4'b0, term_reg} << 1) + {64'b0, dval};
        digit_ovf = |mul10[67:64];
        new_unit  = unit_of(c);

        phase_next = phase_reg;
        term_next  = term_reg;
        unit_next  = unit_reg;
        pos_next   = pos_reg;
        halt_next  = halt_reg;
        do_after   = 1'b0;
        t          = '0;

        if (!halt_reg)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (is_digit)
                    begin
                        term_next  = {60'b0, dval};
                        phase_next = PH_DIGITS;
                    end
                    else
                        t.err = ERR_INVAL;
                end
                PH_DIGITS, PH_SEP:
                begin
                    if (phase_reg == PH_DIGITS && is_digit)
                    begin
                        if (digit_ovf)
                            t.err = ERR_OFLOW;
                        else
                            term_next = mul10[63:0];
                    end
                    else if (is_sep)
                        phase_next = PH_SEP;
                    else if (new_unit == UNIT_NONE)
                        t.err = ERR_INVAL;
                    else
                    begin
                        unit_next  = new_unit;
                        pos_next   = 2'd0;
                        phase_next = (new_unit == UNIT_B) ? PH_BYTES : PH_PREFIX;
                    end
                end
                PH_BYTES:
                begin
                    if (c == tail_char(pos_reg))
                    begin
                        if (pos_reg == 2'd3)
                        begin
                            t.commit   = 1'b1;
                            phase_next = PH_AFTER;
                            pos_next   = 2'd0;
                        end
                        else
                            pos_next = pos_reg + 2'd1;
                    end
                    else
                    begin
                        t.commit   = 1'b1;
                        phase_next = PH_AFTER;
                        pos_next   = 2'd0;
                        do_after   = 1'b1;
                    end
                end
                PH_PREFIX:
                begin
                    if (c == CH_I)
                        phase_next = PH_IB;
                    else
                    begin
                        t.commit   = 1'b1;
                        phase_next = PH_AFTER;
                        do_after   = (c != CH_B);
                    end
                end
                PH_IB:
                begin
                    t.commit   = 1'b1;
                    t.binary   = 1'b1;
                    phase_next = PH_AFTER;
                    do_after   = (c != CH_B);
                end
                PH_AFTER:
                    do_after = 1'b1;
                default:
                    t.err = ERR_INVAL;
            endcase

            // Byte that follows a finished unit
            if (do_after)
            begin
                if (is_sep)
                    phase_next = PH_AFTER;
                else if (is_digit)
                begin
                    term_next  = {60'b0, dval};
                    phase_next = PH_DIGITS;
                end
                else
                    t.err = ERR_INVAL;
            end

            // Close an open unit at the end of the literal
            if (items.last && t.err == ERR_NONE)
            begin
                unique case (phase_next)
                    PH_BYTES, PH_PREFIX: t.commit = 1'b1;
                    PH_IB:
                    begin
                        t.commit = 1'b1;
                        t.binary = 1'b1;
                    end
                    PH_AFTER: ;
                    default: t.err = ERR_INVAL;
                endcase
            end

            if (t.err != ERR_NONE)
                halt_next = 1'b1;
        end

        t.value = term_reg;
        t.unit  = unit_next;
        t.last  = items.last;

        if (items.last)
        begin
            phase_next = PH_START;
            term_next  = '0;
            unit_next  = UNIT_NONE;
            pos_next   = 2'd0;
            halt_next  = 1'b0;
        end
    end

    assign tok       = t;
    assign tok_valid = accept && (t.commit || t.err != ERR_NONE || t.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            term_reg  <= '0;
            unit_reg  <= UNIT_NONE;
            pos_reg   <= 2'd0;
            halt_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            term_reg  <= term_next;
            unit_reg  <= unit_next;
            pos_reg   <= pos_next;
            halt_reg  <= halt_next;
        end
    end

endmodule

### rtl/core/slp_fifo.sv
// ----------------------------------------------------------------------------
// slp_fifo
// Short token queue between parser front and arithmetic back.
// ----------------------------------------------------------------------------
module slp_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  slp_pkg::token_t   wr_data,
    output logic              full,
    input  logic              rd_en,
    output slp_pkg::token_t   rd_data,
    output logic              empty
);
    import slp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             mem [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (rd_en)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (wr_en && !rd_en)
                count_reg <= count_reg + CNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### rtl/core/slp_back.sv
// ----------------------------------------------------------------------------
// slp_back
// Arithmetic back end: scales committed terms by their unit in a pipeline
// of x1000 / x1024 steps, accumulates the total and registers the result.
// ----------------------------------------------------------------------------
module slp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_avail,
    input  slp_pkg::token_t   tok,
    output logic              tok_pop,
    slp_result_if.source      results
);
    import slp_pkg::*;

    typedef struct packed {
        logic        last;
        logic        commit;
        logic        binary;
        logic [2:0]  steps;
        logic        ovf;
        logic [1:0]  err;
        logic [63:0] value;
    } stage_t;

    logic   vld_reg [0:SCALE_STEPS];
    stage_t st_reg  [0:SCALE_STEPS];
    stage_t scaled  [0:SCALE_STEPS-1];
    stage_t load;
    logic   adv;

    logic [63:0] total_reg, total_next;
    logic [1:0]  err_reg, err_next;
    logic [64:0] sum;
    logic        res_valid_reg;
    logic [1:0]  res_status_reg;
    logic [63:0] res_total_reg;
    stage_t      fin;

    // Stall everything while a result waits at the output
    assign adv     = !res_valid_reg || results.ready;
    assign tok_pop = adv && tok_avail;

    always_comb
    begin
        load        = '0;
        load.last   = tok.last;
        load.commit = tok.commit;
        load.binary = tok.binary;
        load.err    = tok.err;
        load.value  = tok.value;
        load.steps  = (tok.unit >= UNIT_K) ? tok.unit - 3'd1 : 3'd0;
    end

    for (genvar i = 0; i < SCALE_STEPS; i++)
    begin : g_scale
        always_comb
        begin
            scaled[i] = st_reg[i];
            if (st_reg[i].steps > 3'(i))
            begin
                if (st_reg[i].binary)
                begin
                    scaled[i].ovf   = st_reg[i].ovf || (|st_reg[i].value[63:54]);
                    scaled[i].value = st_reg[i].value << 10;
                end
                else
                begin
                    scaled[i].ovf   = st_reg[i].ovf || (st_reg[i].value > DEC_STEP_LIMIT);
                    scaled[i].value = (st_reg[i].value << 10) - (st_reg[i].value << 4)
                                      - (st_reg[i].value << 3);
                end
            end
        end
    end

    // Accumulate; the first error of a literal wins
    always_comb
    begin
        fin        = st_reg[SCALE_STEPS];
        total_next = total_reg;
        err_next   = err_reg;
        sum        = {1'b0, total_reg} + {1'b0, fin.value};
        if (err_reg == ERR_NONE)
        begin
            if (fin.commit)
            begin
                if (fin.ovf || sum[64])
                    err_next = ERR_OFLOW;
                else
                    total_next = sum[63:0];
            end
            if (err_next == ERR_NONE && fin.err != ERR_NONE)
                err_next = fin.err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= load;
            for (int i = 0; i < SCALE_STEPS; i++)
                st_reg[i+1] <= scaled[i];
            if (vld_reg[SCALE_STEPS] && fin.last)
            begin
                res_status_reg <= err_next;
                res_total_reg  <= (err_next == ERR_NONE) ? total_next : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SCALE_STEPS; i++)
                vld_reg[i] <= 1'b0;
            total_reg     <= '0;
            err_reg       <= ERR_NONE;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= tok_avail;
            for (int i = 0; i < SCALE_STEPS; i++)
                vld_reg[i+1] <= vld_reg[i];
            res_valid_reg <= vld_reg[SCALE_STEPS] && fin.last;
            if (vld_reg[SCALE_STEPS])
            begin
                if (fin.last)
                begin
                    total_reg <= '0;
                    err_reg   <= ERR_NONE;
                end
                else
                begin
                    total_reg <= total_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    assign results.valid       = res_valid_reg;
    assign results.status      = res_status_reg;
    assign results.total_bytes = res_total_reg;

endmodule

### rtl/core/size_literal_parser.sv
// ----------------------------------------------------------------------------
// size_literal_parser
// Streaming parser for size literals such as "4 KiB, 512 bytes" into a
// 64-bit byte count with an ok / invalid / overflow status.
// ----------------------------------------------------------------------------
// The block takes one byte of literal text per clock while the token queue
// has room, with upper case folded to lower case. A literal is one or more
// terms, each a decimal number, optional spaces or commas, and a unit (b or
// bytes, k, m, g, t with optional i for binary and optional b); a lone
// k/m/g/t at the very end means the decimal unit. Each byte marked last
// produces exactly one result transaction: status 0 ok, 1 invalid, 2
// overflow, and the total (zero unless ok). The first error of a literal
// wins and the block is ready for the next literal on the following byte.
// The result follows the last byte's token through the token queue, the
// four-stage unit scale pipeline (one x1000 or x1024 step per stage) and
// the accumulator. The input keeps taking bytes while a result waits; it
// stalls only once the QUEUE_DEPTH-entry token queue fills.
// ----------------------------------------------------------------------------
module size_literal_parser
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    slp_item_if.sink      items,
    slp_result_if.source  results
);
    import slp_pkg::*;

    token_t front_tok;
    token_t head_tok;
    logic   front_valid;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    // Front: parse bytes, emit commit/error/end tokens
    slp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .tok_space (!q_full),
        .tok_valid (front_valid),
        .tok       (front_tok)
    );

    // Queue: decouple parsing from the arithmetic back end
    slp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_tok),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (head_tok),
        .empty   (q_empty)
    );

    // Back: scale terms, accumulate, hold the result transaction
    slp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_avail (!q_empty),
        .tok       (head_tok),
        .tok_pop   (q_pop),
        .results   (results)
    );

endmodule

### tb/slp_checker.sv
// ----------------------------------------------------------------------------
// slp_checker
// Watches the byte and result channels of the size literal parser, predicts
// the status and byte count of every literal and compares each result.
// ----------------------------------------------------------------------------
module slp_checker
    import slp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    slp_item_if   items,
    slp_result_if results,
    output int    fail_count,
    output int    outstanding
);

    localparam int          REPORT_LIMIT = 10;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        ST_FIRST_DIGIT,
        ST_NUMBER,
        ST_GAP,
        ST_BYTES_TAIL,
        ST_UNIT_PREFIX,
        ST_BINARY_B,
        ST_TERM_DONE
    } parse_phase_e;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] total_bytes;
    } parse_result_t;

    parse_result_t expected_q[$];
    parse_result_t want;
    int            failures;

    // Parser state of the literal being read
    parse_phase_e phase;
    logic [63:0]  number;
    logic [63:0]  sum;
    logic [2:0]   term_unit;
    logic [2:0]   tail_pos;
    logic [1:0]   err;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_gap(input logic [7:0] c);
        return c == " " || c == ",";
    endfunction

    function automatic logic [63:0] unit_scale(input logic [2:0] unit, input logic binary);
        case (unit)
            UNIT_K:  return binary ? (64'd1 << 10) : 64'd1000;
            UNIT_M:  return binary ? (64'd1 << 20) : 64'd1000000;
            UNIT_G:  return binary ? (64'd1 << 30) : 64'd1000000000;
            UNIT_T:  return binary ? (64'd1 << 40) : 64'd1000000000000;
            default: return 64'd1;
        endcase
    endfunction

    function automatic logic [7:0] tail_char(input logic [2:0] pos);
        case (pos)
            3'd0:    return "y";
            3'd1:    return "t";
            3'd2:    return "e";
            default: return "s";
        endcase
    endfunction

    task automatic clear_literal();
        phase     = ST_FIRST_DIGIT;
        number    = '0;
        sum       = '0;
        term_unit = UNIT_NONE;
        tail_pos  = '0;
        err       = ERR_NONE;
    endtask

    // Add number times unit to the sum; overflow of either step is sticky
    task automatic close_term(input logic binary);
        logic [63:0] scale;
        logic [63:0] prod;
        scale     = unit_scale(term_unit, binary);
        phase     = ST_TERM_DONE;
        term_unit = UNIT_NONE;
        tail_pos  = '0;
        if (number > ALL_ONES / scale)
        begin
            err = ERR_OFLOW;
        end
        else
        begin
            prod = number * scale;
            if (prod > ALL_ONES - sum)
            begin
                err = ERR_OFLOW;
            end
            else
            begin
                sum    = sum + prod;
                number = '0;
            end
        end
    endtask

    task automatic push_digit(input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, 4'd0, c[3:0]};
        if (number > (ALL_ONES - d) / 64'd10)
            err = ERR_OFLOW;
        else
            number = number * 64'd10 + d;
    endtask

    task automatic open_unit(input logic [7:0] c);
        case (c)
            "b":     term_unit = UNIT_B;
            "k":     term_unit = UNIT_K;
            "m":     term_unit = UNIT_M;
            "g":     term_unit = UNIT_G;
            "t":     term_unit = UNIT_T;
            default: term_unit = UNIT_NONE;
        endcase
        if (term_unit == UNIT_NONE)
        begin
            err = ERR_INVAL;
        end
        else
        begin
            tail_pos = '0;
            phase    = (term_unit == UNIT_B) ? ST_BYTES_TAIL : ST_UNIT_PREFIX;
        end
    endtask

    // Byte after a finished term: separators, or the first digit of the next
    task automatic term_follow(input logic [7:0] c);
        if (is_digit(c))
        begin
            number = '0;
            phase  = ST_NUMBER;
            push_digit(c);
        end
        else if (!is_gap(c))
        begin
            err = ERR_INVAL;
        end
    endtask

    task automatic consume_byte(input logic [7:0] c);
        case (phase)
            ST_FIRST_DIGIT:
            begin
                if (is_digit(c))
                begin
                    number = '0;
                    phase  = ST_NUMBER;
                    push_digit(c);
                end
                else
                    err = ERR_INVAL;
            end
            ST_NUMBER:
            begin
                if (is_digit(c))
                    push_digit(c);
                else if (is_gap(c))
                    phase = ST_GAP;
                else
                    open_unit(c);
            end
            ST_GAP:
            begin
                if (!is_gap(c))
                    open_unit(c);
            end
            ST_BYTES_TAIL:
            begin
                if (tail_pos < 3'd4 && c == tail_char(tail_pos))
                begin
                    tail_pos = tail_pos + 3'd1;
                    if (tail_pos == 3'd4)
                        close_term(1'b0);
                end
                else
                begin
                    close_term(1'b0);
                    if (err == ERR_NONE)
                        term_follow(c);
                end
            end
            ST_UNIT_PREFIX:
            begin
                if (c == "i")
                    phase = ST_BINARY_B;
                else if (c == "b")
                    close_term(1'b0);
                else
                begin
                    close_term(1'b0);
                    if (err == ERR_NONE)
                        term_follow(c);
                end
            end
            ST_BINARY_B:
            begin
                close_term(1'b1);
                if (c != "b" && err == ERR_NONE)
                    term_follow(c);
            end
            ST_TERM_DONE:
                term_follow(c);
            default:
                err = ERR_INVAL;
        endcase
    endtask

    task automatic predict_byte(input logic [7:0] raw, input logic fin);
        logic [7:0]    c;
        parse_result_t res;
        c = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
        if (err == ERR_NONE)
            consume_byte(c);
        if (fin)
        begin
            if (err == ERR_NONE)
            begin
                case (phase)
                    ST_BYTES_TAIL, ST_UNIT_PREFIX: close_term(1'b0);
                    ST_BINARY_B:                   close_term(1'b1);
                    ST_TERM_DONE:                  ;
                    default:                       err = ERR_INVAL;
                endcase
            end
            res.status      = err;
            res.total_bytes = (err == ERR_NONE) ? sum : 64'd0;
            expected_q.push_back(res);
            clear_literal();
        end
    endtask

    task automatic report_failure(input logic matched, input logic [1:0] st,
                                  input logic [63:0] tot);
        if (failures < REPORT_LIMIT)
        begin
            if (matched)
                $display("result mismatch: status exp %0d got %0d, total exp %0d got %0d",
                         want.status, st, want.total_bytes, tot);
            else
                $display("unexpected result: status %0d total %0d", st, tot);
        end
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_literal();
            expected_q.delete();
            failures    = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (items.valid && items.ready)
                predict_byte(items.char_in, items.last);
            if (results.valid && results.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_failure(1'b0, results.status, results.total_bytes);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (results.status !== want.status ||
                        results.total_bytes !== want.total_bytes)
                        report_failure(1'b1, results.status, results.total_bytes);
                end
            end
            fail_count  <= failures;
            outstanding <= expected_q.size();
        end
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives size literals byte by byte into the parser: a short directed set
// of corner cases, then random well-formed and broken literals, with random
// gaps on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top;

    import slp_pkg::*;

    localparam int RANDOM_BYTES    = 1400;  // stop random stimulus past this
    localparam int MAX_GAP         = 16;    // longest idle draw on either side
    localparam int PRESSURE_AT     = 30;    // result count that starts the hold
    localparam int PRESSURE_CYCLES = 300;   // length of the long hold
    localparam int DRAIN_CYCLES    = 20;    // idle wait after the last result is taken
    localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up

    logic clk;
    logic rst_n;

    slp_item_if   item_ch();
    slp_result_if result_ch();

    int mismatch_total;
    int results_outstanding;
    int quiet_cycles;
    int sent_bytes;

    // Text of the literal being built; the final byte carries last
    logic [7:0] text_q[$];

    size_literal_parser uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    slp_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (item_ch),
        .results     (result_ch),
        .fail_count  (mismatch_total),
        .outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Literal builders
    // ------------------------------------------------------------------------

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Push a lower-case letter, upper case half of the time to exercise folding
    task automatic add_letter(input logic [7:0] c);
        if ($urandom_range(0, 1) == 1)
            text_q.push_back(c - 8'd32);
        else
            text_q.push_back(c);
    endtask

    // Mostly short numbers; a tail of long ones reaches number and term overflow
    task automatic add_number();
        int pick;
        int digits;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            digits = $urandom_range(1, 4);
        else if (pick < 9)
            digits = $urandom_range(5, 13);
        else
            digits = $urandom_range(14, 20);
        for (int i = 0; i < digits; i++)
            text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_gaps();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++)
            text_q.push_back($urandom_range(0, 1) ? 8'h2C : 8'h20);
    endtask

    // b with any prefix of "ytes", or k/m/g/t with optional i and optional b
    task automatic add_unit();
        string tail;
        string prefixes;
        int    pick;
        int    n;
        tail     = "ytes";
        prefixes = "kmgt";
        pick     = $urandom_range(0, 4);
        if (pick == 0)
        begin
            add_letter("b");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                add_letter(tail[i]);
        end
        else
        begin
            add_letter(prefixes[pick - 1]);
            if ($urandom_range(0, 1) == 1)
                add_letter("i");
            if ($urandom_range(0, 1) == 1)
                add_letter("b");
        end
    endtask

    task automatic build_good_literal();
        int terms;
        terms = $urandom_range(1, 3);
        for (int t = 0; t < terms; t++)
        begin
            add_number();
            add_gaps();
            add_unit();
            add_gaps();
        end
    endtask

    // Raw noise, or a good literal with one byte clobbered or cut short
    task automatic build_broken_literal();
        int kind;
        int n;
        kind = $urandom_range(0, 2);
        if (kind == 0)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            build_good_literal();
            n = $urandom_range(0, text_q.size() - 1);
            if (kind == 1)
                text_q[n] = 8'($urandom_range(0, 255));
            else
                while (text_q.size() > n + 1)
                    void'(text_q.pop_back());
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte sender: one transaction per byte, last on the final one. Hold
    // valid high across back-to-back bytes; drop it only for a drawn gap.
    // ------------------------------------------------------------------------
    task automatic send_literal();
        logic burst;
        int   gap;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < text_q.size(); i++)
        begin
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item_ch.valid   <= 1'b1;
            item_ch.char_in <= text_q[i];
            item_ch.last    <= (i == text_q.size() - 1);
            @(posedge clk);
            while (!item_ch.ready)
                @(posedge clk);
            sent_bytes++;
        end
        text_q.delete();
    endtask

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.char_in   <= '0;
        item_ch.last      <= 1'b0;
        sent_bytes        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A number with nothing after it is not a literal
        add_text("8");
        send_literal();
        // Top and bottom byte values, both rejected at the first position
        text_q.push_back(8'hFF);
        send_literal();
        text_q.push_back(8'h00);
        send_literal();
        // Lone unit letter at the very end: decimal tera
        add_text("9T");
        send_literal();
        // Binary unit ending right after the i
        add_text("2Gi");
        send_literal();
        // Several terms: mega with b, comma, kilo closed by the next digit, bytes
        add_text("3mB,4k1b");
        send_literal();
        // First error wins: the digit and unit after the bad byte change nothing
        add_text("q9k");
        send_literal();
        // Term product beyond 64 bits
        add_text("20000000t");
        send_literal();

        // Random literals: mostly well formed so that terms get summed
        while (sent_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) < 7)
                build_good_literal();
            else
                build_broken_literal();
            send_literal();
        end
        item_ch.valid <= 1'b0;

        // Let the last push reach the checker, then drain and wait out latency
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_total == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result receiver: draw a stall before each result, sometimes none for a
    // while, and once hold off long enough for the token queue to fill and
    // back up the byte channel.
    // ------------------------------------------------------------------------
    initial
    begin
        int   taken;
        int   hold;
        logic calm;
        taken = 0;
        calm  = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (taken == PRESSURE_AT)
                hold = PRESSURE_CYCLES;
            else
                hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(result_ch.valid && result_ch.ready))
                @(posedge clk);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
